@@ sv/kcl_pkg.sv @@
// shared types and constants of the keypad code lock
`default_nettype none
package kcl_pkg;

  localparam int MAX_DIGITS_DEF = 8;

  localparam logic [7:0] KEY_NONE   = 8'd0;
  localparam logic [7:0] KEY_ERASE  = 8'd42;
  localparam logic [7:0] KEY_ENTER  = 8'd35;
  localparam logic [7:0] ECHO_STAR  = 8'd42;
  localparam logic [7:0] ECHO_SPACE = 8'd32;
  localparam logic [7:0] ECHO_NONE  = 8'd0;

  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_ERASED   = 3'd2,
    ST_UNLOCK   = 3'd3,
    ST_WRONG    = 3'd4,
    ST_FIRST    = 3'd5,
    ST_NEW_SET  = 3'd6,
    ST_MISMATCH = 3'd7
  } stat_t;

  typedef struct packed {
    logic [7:0] wrong_count;
    logic [7:0] echo_char;
    logic [2:0] echo_position;
    stat_t      status;
  } kcl_result_t;

endpackage
`default_nettype wire

@@ sv/kcl_core.sv @@
// lock state and the per-item decision logic
`default_nettype none
module kcl_core
  import kcl_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic [7:0]  key,
  input  wire logic        cfg_we,
  input  wire logic        cfg_mode,
  output kcl_result_t      result
);

  localparam int LEN_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DIGITS);

  logic             mode_r, mode_nxt;
  logic [7:0]       entry_chars_r [MAX_DIGITS];
  logic [7:0]       entry_chars_nxt [MAX_DIGITS];
  logic [LEN_W-1:0] entry_len_r, entry_len_nxt;
  logic [7:0]       stored_code_r [MAX_DIGITS];
  logic [7:0]       stored_code_nxt [MAX_DIGITS];
  logic [LEN_W-1:0] stored_len_r, stored_len_nxt;
  logic [7:0]       first_code_r [MAX_DIGITS];
  logic [7:0]       first_code_nxt [MAX_DIGITS];
  logic [LEN_W-1:0] first_len_r, first_len_nxt;
  logic             phase_r, phase_nxt;
  logic [7:0]       fail_cnt_r, fail_cnt_nxt;

  logic             match_stored;
  logic             match_first;
  logic [LEN_W-1:0] len_dec;

  // characters beyond the entry length are never compared
  always_comb begin
    match_stored = (entry_len_r == stored_len_r);
    match_first  = (entry_len_r == first_len_r);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (LEN_W'(i) < entry_len_r) begin
        if (entry_chars_r[i] != stored_code_r[i]) match_stored = 1'b0;
        if (entry_chars_r[i] != first_code_r[i])  match_first  = 1'b0;
      end
    end
  end

  assign len_dec = (entry_len_r != '0) ? entry_len_r - LEN_W'(1) : '0;

  always_comb begin
    mode_nxt        = mode_r;
    entry_chars_nxt = entry_chars_r;
    entry_len_nxt   = entry_len_r;
    stored_code_nxt = stored_code_r;
    stored_len_nxt  = stored_len_r;
    first_code_nxt  = first_code_r;
    first_len_nxt   = first_len_r;
    phase_nxt       = phase_r;
    fail_cnt_nxt    = fail_cnt_r;
    result.status        = ST_IGNORED;
    result.echo_position = 3'd0;
    result.echo_char     = ECHO_NONE;

    if (step_en) begin
      if (key == KEY_NONE) begin
        result.status = ST_IGNORED;
      end else if (key == KEY_ERASE) begin
        entry_len_nxt        = len_dec;
        result.status        = ST_ERASED;
        result.echo_position = 3'(len_dec);
        result.echo_char     = ECHO_SPACE;
      end else if (key == KEY_ENTER) begin
        entry_len_nxt = '0;
        if (!mode_r) begin
          if (match_stored) begin
            result.status = ST_UNLOCK;
          end else begin
            result.status = ST_WRONG;
            fail_cnt_nxt  = fail_cnt_r + 8'd1;
          end
        end else if (!phase_r) begin
          first_code_nxt = entry_chars_r;
          first_len_nxt  = entry_len_r;
          phase_nxt      = 1'b1;
          result.status  = ST_FIRST;
        end else begin
          if (match_first) begin
            stored_code_nxt = entry_chars_r;
            stored_len_nxt  = entry_len_r;
            result.status   = ST_NEW_SET;
          end else begin
            result.status = ST_MISMATCH;
            fail_cnt_nxt  = fail_cnt_r + 8'd1;
          end
          phase_nxt = 1'b0;
        end
      end else if (entry_len_r < LEN_MAX) begin
        entry_chars_nxt[entry_len_r[IDX_W-1:0]] = key;
        entry_len_nxt        = entry_len_r + LEN_W'(1);
        result.status        = ST_STORED;
        result.echo_position = 3'(entry_len_r);
        result.echo_char     = ECHO_STAR;
      end else begin
        result.status = ST_IGNORED;
      end
    end

    // mode write also drops any partial entry and setup progress
    if (cfg_we) begin
      mode_nxt      = cfg_mode;
      entry_len_nxt = '0;
      phase_nxt     = 1'b0;
    end

    result.wrong_count = fail_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      entry_len_r  <= '0;
      stored_len_r <= '0;
      first_len_r  <= '0;
      phase_r      <= 1'b0;
      fail_cnt_r   <= 8'd0;
    end else begin
      mode_r       <= mode_nxt;
      entry_len_r  <= entry_len_nxt;
      stored_len_r <= stored_len_nxt;
      first_len_r  <= first_len_nxt;
      phase_r      <= phase_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_chars_r <= entry_chars_nxt;
    stored_code_r <= stored_code_nxt;
    first_code_r  <= first_code_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_len_r <= LEN_MAX) && (stored_len_r <= LEN_MAX) && (first_len_r <= LEN_MAX))
    else $error("code length beyond buffer");

  a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (key == KEY_ENTER) |=> (entry_len_r == '0))
    else $error("entry not cleared after enter");

  a_fail_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !cfg_we && ((result.status == ST_WRONG) || (result.status == ST_MISMATCH))
    |=> (fail_cnt_r == $past(fail_cnt_r) + 8'd1))
    else $error("failure count did not advance");

  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(fail_cnt_r) && $stable(stored_len_r))
    else $error("lock state changed without an item");

  a_verify_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !mode_r |=> $stable(stored_len_r))
    else $error("stored code changed in verify mode");

endmodule
`default_nettype wire

@@ sv/keypad_code_lock_unit.sv @@
// top level of the keypad code lock: input stage, lock core and output register
//
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | in_tdata[7:0] key
// out_    | out | out_tvalid/out_tready | out_tdata: status, echo_position, echo_char, wrong_count
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_data setup_mode
//
// one item per cycle sustained while out_tready does not stall the result register; each item is
// captured in the input register and then registered into the result register, which drives out_tdata
// the lock state is updated while the item moves from input to result register
// rst_n is synchronous: empty code, verify mode, zero failure count, stages empty
// a stalled result register holds its item; the input register takes one more
`default_nettype none
module keypad_code_lock_unit
  import kcl_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] key
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] status, [5:3] echo_position, [13:6] echo_char, [21:14] wrong_count, [23:22] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_data
);

  logic        in_vld_r;
  logic [7:0]  key_r;
  logic        out_vld_r;
  kcl_result_t out_res_r;
  kcl_result_t core_res;
  logic        advance;
  logic        cfg_we;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  kcl_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .key      (key_r),
    .cfg_we   (cfg_we),
    .cfg_mode (cfg_data),
    .result   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(kcl_result_t))'(0), out_res_r};

  a_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((out_res_r.status == ST_IGNORED) || (out_res_r.status == ST_UNLOCK)
      || (out_res_r.status == ST_WRONG) || (out_res_r.status == ST_FIRST)
      || (out_res_r.status == ST_NEW_SET) || (out_res_r.status == ST_MISMATCH))
    |-> (out_res_r.echo_char == ECHO_NONE) && (out_res_r.echo_position == 3'd0))
    else $error("echo on a result without echo");

  a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_tready |=> in_vld_r && $stable(key_r))
    else $error("input item lost while result stalled");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed item not presented");

endmodule
`default_nettype wire

@@ tb/keypad_code_lock_unit_checker.sv @@
// result checker of the keypad code lock: watches all three channels and predicts every result
`default_nettype none
module keypad_code_lock_unit_checker
  import kcl_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [7:0]            in_tdata,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic                  cfg_data,
  output int                         pending,
  output int                         errors
);

  localparam int RES_W = $bits(kcl_result_t);

  logic       setup_mode;
  logic [7:0] entry [MAX_DIGITS];
  int         entry_len;
  logic [7:0] secret_code [MAX_DIGITS];
  int         secret_len;
  logic [7:0] candidate [MAX_DIGITS];
  int         cand_len;
  logic       confirming;
  logic [7:0] fail_count;
  int         mismatches = 0;

  kcl_result_t expected_q[$];

  assign errors = mismatches;

  // only entries below the common length are compared, so stale chars never matter
  function automatic bit entry_matches(input bit vs_candidate);
    int n;
    n = vs_candidate ? cand_len : secret_len;
    if (entry_len != n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (entry[i] != (vs_candidate ? candidate[i] : secret_code[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic kcl_result_t lock_step(input logic [7:0] key);
    kcl_result_t r;
    r.status        = ST_IGNORED;
    r.echo_position = 3'd0;
    r.echo_char     = ECHO_NONE;
    if (key == KEY_ERASE) begin
      if (entry_len > 0) entry_len--;
      r.status        = ST_ERASED;
      r.echo_position = 3'(entry_len);
      r.echo_char     = ECHO_SPACE;
    end else if (key == KEY_ENTER) begin
      if (!setup_mode) begin
        if (entry_matches(1'b0)) begin
          r.status = ST_UNLOCK;
        end else begin
          r.status = ST_WRONG;
          fail_count++;
        end
      end else if (!confirming) begin
        candidate  = entry;
        cand_len   = entry_len;
        confirming = 1'b1;
        r.status   = ST_FIRST;
      end else begin
        if (entry_matches(1'b1)) begin
          secret_code = entry;
          secret_len  = entry_len;
          r.status    = ST_NEW_SET;
        end else begin
          r.status = ST_MISMATCH;
          fail_count++;
        end
        confirming = 1'b0;
      end
      entry_len = 0;
    end else if (key != KEY_NONE && entry_len < MAX_DIGITS) begin
      entry[entry_len] = key;
      r.echo_position  = 3'(entry_len);
      r.echo_char      = ECHO_STAR;
      r.status         = ST_STORED;
      entry_len++;
    end
    r.wrong_count = fail_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    kcl_result_t want;
    kcl_result_t got;
    if (!rst_n) begin
      setup_mode = 1'b0;
      entry_len  = 0;
      secret_len = 0;
      cand_len   = 0;
      confirming = 1'b0;
      fail_count = 8'd0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        entry[i]       = 8'd0;
        secret_code[i] = 8'd0;
        candidate[i]   = 8'd0;
      end
      expected_q.delete();
    end else begin
      // a mode write drops the entry and restarts the setup dialog
      if (cfg_valid && cfg_ready) begin
        setup_mode = cfg_data;
        entry_len  = 0;
        confirming = 1'b0;
      end
      if (out_tvalid && out_tready) begin
        got = kcl_result_t'(out_tdata[RES_W-1:0]);
        if (expected_q.size() == 0) begin
          $error("result with no item pending: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", {5'd0, want.status}, {5'd0, got.status});
          check_field("echo_position", {5'd0, want.echo_position}, {5'd0, got.echo_position});
          check_field("echo_char", want.echo_char, got.echo_char);
          check_field("wrong_count", want.wrong_count, got.wrong_count);
          check_field("padding", 8'd0, 8'(out_tdata[OUT_DATA_W-1:RES_W]));
        end
      end
      if (in_tvalid && in_tready) expected_q.push_back(lock_step(in_tdata));
    end
    pending <= expected_q.size();
  end

endmodule
`default_nettype wire

@@ tb/keypad_code_lock_unit_tb.sv @@
// top of the keypad code lock testbench: clock, reset, key stimulus and verdict
`default_nettype none
module keypad_code_lock_unit_tb;
  import kcl_pkg::*;

  localparam int MAX_DIGITS = MAX_DIGITS_DEF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;
  int                    pending;
  int                    errors;

  int         sent = 0;
  int         burst_left = 0;
  logic       mode_now = 1'b0;
  logic [7:0] secret[$];
  logic [7:0] attempt[$];
  logic [7:0] code_a[$];
  int         stall_style = 0;
  int         style_left = 0;

  keypad_code_lock_unit #(.MAX_DIGITS(MAX_DIGITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  keypad_code_lock_unit_checker #(.MAX_DIGITS(MAX_DIGITS)) lock_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("keypad_code_lock_unit verification failed");
    $finish;
  end

  // result side: the stall style is picked anew whenever its random run length expires
  always @(posedge clk) begin
    if (style_left == 0) begin
      style_left  <= $urandom_range(20, 80);
      stall_style <= $urandom_range(0, 3);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic logic [7:0] any_digit();
    logic [7:0] d;
    do d = 8'($urandom_range(1, 255)); while (d == KEY_ERASE || d == KEY_ENTER);
    return d;
  endfunction

  task automatic send_key(input logic [7:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= k;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent++;
  endtask

  task automatic send_all();
    foreach (attempt[i]) send_key(attempt[i]);
  endtask

  task automatic make_code(input int len);
    attempt.delete();
    repeat (len) attempt.push_back(any_digit());
  endtask

  // a wrong digit typed and erased again; never past a full buffer
  task automatic add_typo();
    int pos;
    pos = $urandom_range(0, attempt.size() < MAX_DIGITS ? attempt.size() : MAX_DIGITS - 1);
    attempt.insert(pos, KEY_ERASE);
    attempt.insert(pos, any_digit());
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_now = m;
  endtask

  initial begin
    int target;
    int pick;
    int len;
    int pos;
    logic [7:0] d;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty code after reset, full buffer, setup and verify
    write_mode(1'b0);
    send_key(KEY_NONE);
    send_key(KEY_ERASE);
    send_key(KEY_ENTER);
    send_key(8'h01); send_key(8'hFF); send_key(8'h80); send_key(8'h7F);
    send_key(8'h02); send_key(8'hFE); send_key(8'h24); send_key(8'h2B);
    send_key(8'h09);
    send_key(KEY_ERASE);
    send_key(KEY_ENTER);
    write_mode(1'b1);
    send_key(8'hAA); send_key(8'h55); send_key(KEY_ENTER);
    send_key(8'hAA); send_key(8'h55); send_key(KEY_ENTER);
    send_key(8'h11); send_key(KEY_ENTER);
    send_key(8'h12); send_key(KEY_ENTER);
    write_mode(1'b0);
    send_key(8'hAA); send_key(8'h55); send_key(KEY_ENTER);
    secret = '{8'hAA, 8'h55};

    // bare enters against a nonempty code: enough wrong tries to wrap the counter
    repeat (260) send_key(KEY_ENTER);

    target = sent + 160;
    while (sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        if (mode_now) write_mode(1'b0);
        attempt = secret;
        case ($urandom_range(0, 3))
          0: ;
          1: add_typo();
          2: make_code($urandom_range(0, MAX_DIGITS + 2));
          default: begin
            if (attempt.size() == 0 || $urandom_range(0, 2) == 0) begin
              attempt.push_back(any_digit());
            end else if ($urandom_range(0, 1) == 1) begin
              void'(attempt.pop_back());
            end else begin
              pos = $urandom_range(0, attempt.size() - 1);
              do d = any_digit(); while (d == attempt[pos]);
              attempt[pos] = d;
            end
          end
        endcase
        send_all();
        send_key(KEY_ENTER);
      end else if (pick < 7) begin
        write_mode(1'b1);
        pick = $urandom_range(0, 9);
        len = (pick == 0) ? 0 : (pick == 1) ? MAX_DIGITS : $urandom_range(1, 6);
        make_code(len);
        code_a = attempt;
        send_all();
        send_key(KEY_ENTER);
        attempt = code_a;
        pick = $urandom_range(0, 9);
        if (pick < 2) make_code($urandom_range(1, MAX_DIGITS));
        else if (pick < 4) add_typo();
        send_all();
        send_key(KEY_ENTER);
        if (pick >= 2) secret = code_a;
      end else if (pick < 9) begin
        repeat ($urandom_range(3, 12)) begin
          pick = $urandom_range(0, 19);
          d = (pick < 2) ? KEY_NONE : (pick < 6) ? KEY_ERASE : (pick < 9) ? KEY_ENTER : any_digit();
          send_key(d);
        end
      end else begin
        // a mode write in the middle of an entry throws the entry away
        make_code($urandom_range(1, 5));
        send_all();
        write_mode(1'($urandom_range(0, 1)));
        if (!mode_now) begin
          attempt = secret;
          send_all();
          send_key(KEY_ENTER);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("keypad_code_lock_unit verification clean");
    end else begin
      $display("keypad_code_lock_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
